// ----- rtl/core/itas_pkg.sv -----
// ----------------------------------------------------------------------------
// itas_pkg: shared types and constants of the trusted IPv4 address set
// Table geometry, command codes, the slot layout and the match result
// that the compare unit hands to the sequencer.
// ----------------------------------------------------------------------------
package itas_pkg;

  // Table geometry. BUCKETS must be a power of two, since the bucket is the
  // low bits of the address.
  localparam int BUCKETS  = 128;
  localparam int WAYS     = 4;
  localparam int SLOTS    = BUCKETS * WAYS;
  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int ADDR_W   = 32;

  // Command codes carried on the request side.
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // One stored slot: a valid flag over the address.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  // Result of comparing one slot against the request address.
  typedef struct packed {
    logic hit;
    logic empty;
  } way_match_t;

  // Flat memory index of a way within a bucket.
  function automatic logic [SLOT_W-1:0] slot_index(input logic [BUCKET_W-1:0] bucket,
                                                   input logic [WAY_W-1:0] way);
    logic [SLOT_W-1:0] base;
    base = SLOT_W'(bucket) * SLOT_W'(WAYS);
    return base + SLOT_W'(way);
  endfunction

endpackage

// ----- rtl/core/itas_slot_ram.sv -----
// ----------------------------------------------------------------------------
// itas_slot_ram: single-port slot memory
// One read or write per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module itas_slot_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when enabled, otherwise read the addressed word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/core/itas_way_match.sv -----
// ----------------------------------------------------------------------------
// itas_way_match: shared slot compare unit
// Checks one slot read from the table against the request address and
// reports whether it holds that address or is free.
// ----------------------------------------------------------------------------
module itas_way_match (
  input  itas_pkg::slot_t                 slot,
  input  logic [itas_pkg::ADDR_W-1:0]     key,
  output itas_pkg::way_match_t            result
);
  import itas_pkg::*;

  // A hit needs a valid slot with an equal address.
  always_comb begin
    result.hit   = slot.valid && (slot.addr == key);
    result.empty = !slot.valid;
  end

endmodule

// ----- rtl/core/ipv4_trusted_address_set.sv -----
// ----------------------------------------------------------------------------
// ipv4_trusted_address_set: hashed membership set of IPv4 addresses
// Lookup, add, delete and clear on a table of fixed-way buckets.
// ----------------------------------------------------------------------------
// Usage:
// A request arrives on the s_ channel: the command in s_tuser, the address in
// s_tdata. Each request gives exactly one response on the m_ channel with
// was_present and status. The bucket is the low bits of the address.
// One request is in work at a time. The sequencer reads the ways of the
// bucket one per cycle through the single memory port and the shared compare
// unit, then writes back at most one slot. The response register is loaded
// and s_tready rises at the same edge, except for a clear, so a new request
// is not taken before the last one has been answered. A clear request also
// sweeps the whole memory, one slot per cycle, before s_tready rises.
// Reset starts the same clearing sweep; s_tready stays low until it ends. The
// response sits in an output register: a stalled receiver does not stop the
// next request from being accepted, but its response waits until the previous
// one has been taken.
// ----------------------------------------------------------------------------
module ipv4_trusted_address_set (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] ip_address
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] was_present, [1] status, [7:2] zero
);
  import itas_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_SWEEP
  } state_t;

  state_t              state;
  cmd_t                cmd;
  logic [ADDR_W-1:0]   addr;
  logic [BUCKET_W-1:0] bucket;
  logic [WAY_W:0]      way_rd;
  logic [WAY_W-1:0]    way_cmp;
  logic                cmp_vld;
  logic                hit;
  logic [WAY_W-1:0]    hit_way;
  logic                free_found;
  logic [WAY_W-1:0]    free_way;
  logic [SLOT_W-1:0]   sweep_cnt;
  logic                out_present;
  logic                out_status;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_addr;
  slot_t               ram_wdata;
  slot_t               ram_rdata;
  way_match_t          match;
  logic                out_free;
  logic                issue;

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {6'd0, out_status, out_present};
  assign out_free = !m_tvalid || m_tready;
  assign issue    = (way_rd < (WAY_W + 1)'(WAYS));

  itas_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH (SLOT_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  itas_way_match u_match (
    .slot   (ram_rdata),
    .key    (addr),
    .result (match)
  );

  // Memory port: reads while scanning, one write-back at the end, and the
  // clearing sweep.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = slot_index(bucket, way_rd[WAY_W-1:0]);
    ram_wdata = '0;
    unique case (state)
      ST_SWEEP: begin
        ram_we   = 1'b1;
        ram_addr = sweep_cnt;
      end
      ST_ACT: begin
        if (out_free) begin
          if (cmd == CMD_ADD && !hit && free_found) begin
            ram_we         = 1'b1;
            ram_addr       = slot_index(bucket, free_way);
            ram_wdata.valid = 1'b1;
            ram_wdata.addr  = addr;
          end else if (cmd == CMD_DELETE && hit) begin
            ram_we   = 1'b1;
            ram_addr = slot_index(bucket, hit_way);
          end
        end
      end
      ST_IDLE, ST_SCAN: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer with the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      sweep_cnt <= '0;
      m_tvalid  <= 1'b0;
      cmp_vld   <= 1'b0;
    end else begin
      // The taken response is dropped unless a new one is loaded this cycle.
      if (m_tvalid && m_tready && state != ST_ACT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd        <= cmd_t'(s_tuser);
            addr       <= s_tdata;
            bucket     <= s_tdata[BUCKET_W-1:0];
            way_rd     <= '0;
            cmp_vld    <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue the next way while comparing the one read last cycle.
          if (issue) begin
            way_rd <= way_rd + 1'b1;
          end
          cmp_vld <= issue;
          way_cmp <= way_rd[WAY_W-1:0];
          if (cmp_vld) begin
            if (match.hit && !hit) begin
              hit     <= 1'b1;
              hit_way <= way_cmp;
            end
            if (match.empty && !free_found) begin
              free_found <= 1'b1;
              free_way   <= way_cmp;
            end
            if (way_cmp == WAY_W'(WAYS - 1)) begin
              state <= ST_ACT;
            end
          end
        end
        ST_ACT: begin
          if (out_free) begin
            m_tvalid    <= 1'b1;
            out_present <= hit;
            out_status  <= (cmd == CMD_ADD) && !hit && !free_found;
            if (cmd == CMD_CLEAR) begin
              sweep_cnt <= '0;
              state     <= ST_SWEEP;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == SLOT_W'(SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // An accepted request blocks the next one in the following cycle.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in work");

  // The table is never written while the bucket is scanned.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> !ram_we)
    else $error("table written during scan");

  // A full-bucket refusal never reports the address as present.
  a_full_not_present: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> !m_tdata[0])
    else $error("full status with address present");

  // Reset starts the clearing sweep, so no request is taken right after it.
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("request port open right after reset");
`endif

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench of the trusted IPv4 address set
// Sends lookup, add, delete and clear requests on the stream input and keeps
// a copy of the bucket table that predicts each response. Every response is
// checked against the oldest outstanding prediction. The sender works in
// bursts with random gaps and the receiver stalls at random or in patterns.
// ----------------------------------------------------------------------------
module tb;
  import itas_pkg::*;

  typedef struct packed {
    logic was_present;
    logic status;
  } membership_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] ip_address
  logic [1:0]  s_tuser = '0;   // [1:0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [0] was_present, [1] status, [7:2] zero

  // Model of the table: one valid flag and one address per slot.
  logic              table_valid [SLOTS];
  logic [ADDR_W-1:0] table_addr  [SLOTS];

  membership_t       pending_answers[$];
  logic [ADDR_W-1:0] recent_addrs[$];
  int                focus_bucket [4];
  int                error_count = 0;
  int                hold_left = 0;
  rx_mode_t          rx_mode = RX_ALWAYS;
  logic [15:0]       rx_pattern = 16'b1011_0011_1000_1111;

  ipv4_trusted_address_set dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // Applies one command to the table copy and returns the predicted response.
  function automatic membership_t predict_membership(cmd_t cmd, logic [ADDR_W-1:0] addr);
    membership_t answer;
    int          bucket;
    int          hit_way;
    int          free_way;
    int          idx;
    answer   = '0;
    bucket   = int'(addr[BUCKET_W-1:0]);
    hit_way  = -1;
    free_way = -1;
    for (int w = 0; w < WAYS; w++) begin
      idx = bucket * WAYS + w;
      if (table_valid[idx] && table_addr[idx] == addr && hit_way < 0) hit_way = w;
      if (!table_valid[idx] && free_way < 0) free_way = w;
    end
    case (cmd)
      CMD_ADD: begin
        if (hit_way < 0) begin
          if (free_way < 0) begin
            answer.status = 1'b1;
          end else begin
            table_valid[bucket * WAYS + free_way] = 1'b1;
            table_addr[bucket * WAYS + free_way]  = addr;
          end
        end
      end
      CMD_DELETE: begin
        if (hit_way >= 0) table_valid[bucket * WAYS + hit_way] = 1'b0;
      end
      CMD_CLEAR: begin
        for (int s = 0; s < SLOTS; s++) table_valid[s] = 1'b0;
      end
      default: begin
      end
    endcase
    answer.was_present = (hit_way >= 0);
    return answer;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Offers one request and holds it until the block takes it.
  task automatic send_request(cmd_t cmd, logic [ADDR_W-1:0] addr);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = addr;
    do @(posedge clk); while (!s_tready);
    pending_answers.push_back(predict_membership(cmd, addr));
    if (cmd == CMD_ADD) begin
      recent_addrs.push_back(addr);
      if (recent_addrs.size() > 48) void'(recent_addrs.pop_front());
    end
  endtask

  // Drops the request for a number of cycles, with noise on the data lines.
  task automatic idle_sender(int cycles);
    @(negedge clk);
    s_tvalid = 1'b0;
    s_tdata  = $urandom;
    s_tuser  = 2'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Receiver: a long hold-off when asked, otherwise the current stall mode.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      case (rx_mode)
        RX_ALWAYS: m_tready = 1'b1;
        RX_RANDOM: m_tready = ($urandom_range(0, 99) < 60);
        default: begin
          m_tready   = rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
        end
      endcase
    end
  end

  // Compares each response with the oldest prediction.
  always @(posedge clk) begin : check_response
    membership_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("response 0x%02h with no request outstanding", m_tdata));
      end else begin
        want = pending_answers.pop_front();
        if (m_tdata[0] !== want.was_present)
          report_mismatch($sformatf("was_present %b, predicted %b", m_tdata[0],
                                    want.was_present));
        if (m_tdata[1] !== want.status)
          report_mismatch($sformatf("status %b, predicted %b", m_tdata[1], want.status));
      end
    end
  end

  // Extremes of the address, a full bucket, deletes and both kinds of clear.
  task automatic test_directed();
    rx_mode = RX_ALWAYS;
    send_request(CMD_LOOKUP, 32'h0000_0000);
    send_request(CMD_DELETE, 32'hFFFF_FFFF);
    send_request(CMD_ADD,    32'h0000_0000);
    send_request(CMD_ADD,    32'hFFFF_FFFF);
    send_request(CMD_ADD,    32'h0000_0000);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF);
    for (int w = 0; w < WAYS; w++) send_request(CMD_ADD, 32'h0000_0005 + 32'(w * BUCKETS));
    send_request(CMD_ADD,    32'h0000_0205);
    send_request(CMD_LOOKUP, 32'h0000_0205);
    send_request(CMD_DELETE, 32'h0000_0085);
    send_request(CMD_ADD,    32'h0000_0205);
    send_request(CMD_ADD,    32'hFFFF_FF85);
    send_request(CMD_LOOKUP, 32'h0000_0085);
    send_request(CMD_CLEAR,  32'h0000_0005);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF);
    send_request(CMD_CLEAR,  32'hA5A5_A5A5);
    wait_for_drain();
  endtask

  // The receiver holds off while requests keep coming into one bucket.
  task automatic test_backpressure();
    @(posedge clk);
    hold_left = 400;
    for (int i = 0; i < 24; i++)
      send_request(cmd_t'($urandom_range(0, 2)),
                   {7'($urandom_range(0, 5)), 25'd0} | 32'd77);
    wait_for_drain();
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    int                r;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(0, 99);
    if (r < 45 && recent_addrs.size() > 0) begin
      a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
    end else if (r < 90) begin
      a = $urandom;
      if ($urandom_range(0, 1)) a[ADDR_W-1:BUCKET_W] = (ADDR_W-BUCKET_W)'($urandom_range(0, 7));
      a[BUCKET_W-1:0] = BUCKET_W'(focus_bucket[$urandom_range(0, 3)]);
    end else begin
      a = $urandom;
    end
    return a;
  endfunction

  function automatic cmd_t pick_command();
    int r;
    r = $urandom_range(0, 199);
    if (r < 3) return CMD_CLEAR;
    if (r < 83) return CMD_ADD;
    if (r < 143) return CMD_LOOKUP;
    return CMD_DELETE;
  endfunction

  // Mostly traffic on a few buckets, so that buckets fill and addresses recur.
  task automatic test_random(int total);
    int sent;
    int burst_len;
    int next_shuffle;
    sent         = 0;
    next_shuffle = 0;
    while (sent < total) begin
      // Every 160 requests or so, new focus buckets and a new receiver mode.
      if (sent >= next_shuffle) begin
        for (int i = 0; i < 4; i++) focus_bucket[i] = $urandom_range(0, BUCKETS - 1);
        if (sent == 0) begin
          focus_bucket[0] = 0;
          focus_bucket[1] = BUCKETS - 1;
        end
        rx_mode      = rx_mode_t'($urandom_range(0, 2));
        rx_pattern   = 16'($urandom) | 16'h0001;
        next_shuffle = next_shuffle + 160;
      end
      if (sent >= total / 2 && sent - 16 < total / 2) wait_for_drain();
      burst_len = $urandom_range(1, 16);
      for (int i = 0; i < burst_len; i++) send_request(pick_command(), pick_address());
      sent += burst_len;
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
    end
    wait_for_drain();
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      table_valid[s] = 1'b0;
      table_addr[s]  = '0;
    end
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_backpressure();
    test_random(1250);
    repeat (WAYS + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/itas_pkg.sv
rtl/core/itas_slot_ram.sv
rtl/core/itas_way_match.sv
rtl/core/ipv4_trusted_address_set.sv
verif/tb.sv
